// ===== rtl/clt_pkg.sv =====
// shared types, constants and the state/flag tables of the command line tokenizer
// used by the interfaces and by the top level; no dependencies
`timescale 1ns / 1ps

package clt_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CHAR_WIDTH  = 8;
   localparam int WCNT_WIDTH  = 16;

   // flag bits of one table entry
   localparam logic [4:0] F_START = 5'h01;
   localparam logic [4:0] F_COPY  = 5'h02;
   localparam logic [4:0] F_EWORD = 5'h04;
   localparam logic [4:0] F_EVAR  = 5'h08;
   localparam logic [4:0] F_ECMD  = 5'h10;

   localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h0a;
   localparam logic [CHAR_WIDTH-1:0] CH_SQ    = 8'h27;
   localparam logic [CHAR_WIDTH-1:0] CH_DQ    = 8'h22;
   localparam logic [CHAR_WIDTH-1:0] CH_BSL   = 8'h5c;
   localparam logic [CHAR_WIDTH-1:0] CH_SEMI  = 8'h3b;
   localparam logic [CHAR_WIDTH-1:0] CH_DOLL  = 8'h24;

   typedef enum logic [2:0] {
      CLS_END   = 3'd0,
      CLS_BLANK = 3'd1,
      CLS_OTHER = 3'd2,
      CLS_SQ    = 3'd3,
      CLS_DQ    = 3'd4,
      CLS_BSL   = 3'd5,
      CLS_SEMI  = 3'd6,
      CLS_DOLL  = 3'd7
   } class_type;

   typedef enum logic [9:0] {
      ST_END   = 10'b00_0000_0001,
      ST_BLANK = 10'b00_0000_0010,
      ST_WORD  = 10'b00_0000_0100,
      ST_SQ    = 10'b00_0000_1000,
      ST_DQ    = 10'b00_0001_0000,
      ST_BSL   = 10'b00_0010_0000,
      ST_SEMI  = 10'b00_0100_0000,
      ST_VAR   = 10'b00_1000_0000,
      ST_EVAR  = 10'b01_0000_0000,
      ST_DQBSL = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] out_char;
      logic                  copy_flag;
      logic                  start_word;
      logic                  end_word;
      logic                  end_variable;
      logic                  end_command;
      logic                  string_done;
      logic [WCNT_WIDTH-1:0] word_count;
   } rsp_type;

   function automatic class_type classify(input logic [CHAR_WIDTH-1:0] ch);
      class_type cls;
      case (ch)
         CH_NUL:                  cls = CLS_END;
         CH_SPACE, CH_TAB, CH_LF: cls = CLS_BLANK;
         CH_SQ:                   cls = CLS_SQ;
         CH_DQ:                   cls = CLS_DQ;
         CH_BSL:                  cls = CLS_BSL;
         CH_SEMI:                 cls = CLS_SEMI;
         CH_DOLL:                 cls = CLS_DOLL;
         default:                 cls = CLS_OTHER;
      endcase
      return cls;
   endfunction

   // rows shared by the blank and after-semicolon states and, but for dollar, the word state
   function automatic state_type open_next(input class_type cls, input state_type on_blank);
      state_type nx;
      unique case (cls)
         CLS_END:   nx = ST_END;
         CLS_BLANK: nx = on_blank;
         CLS_OTHER: nx = ST_WORD;
         CLS_SQ:    nx = ST_SQ;
         CLS_DQ:    nx = ST_DQ;
         CLS_BSL:   nx = ST_BSL;
         CLS_SEMI:  nx = ST_SEMI;
         CLS_DOLL:  nx = ST_VAR;
         default:   nx = ST_END;
      endcase
      return nx;
   endfunction

   function automatic state_type next_state(input state_type st, input class_type cls);
      state_type nx;
      unique case (st)
         ST_END:   nx = ST_END;
         ST_WORD:  nx = (cls == CLS_DOLL) ? ST_WORD : open_next(cls, ST_BLANK);
         ST_SQ:    nx = (cls == CLS_END) ? ST_END : (cls == CLS_SQ) ? ST_WORD : ST_SQ;
         ST_DQ: begin
            case (cls)
               CLS_END: nx = ST_END;
               CLS_DQ:  nx = ST_WORD;
               CLS_BSL: nx = ST_DQBSL;
               default: nx = ST_DQ;
            endcase
         end
         ST_BSL:   nx = (cls == CLS_END) ? ST_END : ST_WORD;
         ST_SEMI:  nx = open_next(cls, ST_SEMI);
         ST_VAR: begin
            case (cls)
               CLS_END:   nx = ST_END;
               CLS_BLANK: nx = ST_BLANK;
               CLS_SEMI:  nx = ST_SEMI;
               default:   nx = ST_VAR;
            endcase
         end
         ST_EVAR:  nx = (cls == CLS_END) ? ST_END : ST_VAR;
         ST_DQBSL: nx = (cls == CLS_END) ? ST_END : ST_DQ;
         default:  nx = open_next(cls, ST_BLANK);
      endcase
      return nx;
   endfunction

   function automatic logic [4:0] open_flags(input class_type cls, input logic semi_ends);
      logic [4:0] fl;
      case (cls)
         CLS_END:   fl = F_ECMD;
         CLS_BLANK: fl = '0;
         CLS_OTHER: fl = F_START | F_COPY;
         CLS_SEMI:  fl = semi_ends ? F_ECMD : '0;
         default:   fl = F_START;
      endcase
      return fl;
   endfunction

   // word and variable rows differ only in the end mark
   function automatic logic [4:0] name_flags(input class_type cls, input logic [4:0] mark);
      logic [4:0] fl;
      case (cls)
         CLS_END:   fl = F_ECMD | mark;
         CLS_BLANK: fl = mark;
         CLS_OTHER: fl = F_COPY;
         CLS_SEMI:  fl = F_ECMD | mark;
         default:   fl = '0;
      endcase
      return fl;
   endfunction

   function automatic logic [4:0] flags_of(input state_type st, input class_type cls);
      logic [4:0] fl;
      unique case (st)
         ST_END:   fl = (cls == CLS_END) ? F_ECMD : '0;
         ST_WORD:  fl = name_flags(cls, F_EWORD);
         ST_SQ:    fl = (cls == CLS_END) ? (F_ECMD | F_EWORD) :
                        (cls == CLS_SQ) ? 5'(0) : F_COPY;
         ST_DQ:    fl = (cls == CLS_END) ? (F_ECMD | F_EWORD) :
                        (cls == CLS_DQ) ? 5'(0) : F_COPY;
         ST_BSL:   fl = (cls == CLS_END) ? (F_ECMD | F_EWORD) : F_COPY;
         ST_SEMI:  fl = open_flags(cls, 1'b0);
         ST_VAR:   fl = name_flags(cls, F_EVAR);
         ST_EVAR:  fl = (cls == CLS_END) ? (F_ECMD | F_EVAR) : F_COPY;
         ST_DQBSL: fl = (cls == CLS_END) ? (F_ECMD | F_EWORD) : F_COPY;
         default:  fl = open_flags(cls, 1'b1);
      endcase
      return fl;
   endfunction

endpackage

// ===== rtl/clt_if.sv =====
// request and response channel interfaces of the command line tokenizer
// depends on clt_pkg for widths
`timescale 1ns / 1ps

interface clt_req_if
   import clt_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface clt_rsp_if
   import clt_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] out_char;
   logic                  copy_flag;
   logic                  start_word;
   logic                  end_word;
   logic                  end_variable;
   logic                  end_command;
   logic                  string_done;
   logic [WCNT_WIDTH-1:0] word_count;

   modport source (output valid, output out_char, output copy_flag, output start_word,
                   output end_word, output end_variable, output end_command,
                   output string_done, output word_count, input ready);
   modport sink   (input valid, input out_char, input copy_flag, input start_word,
                   input end_word, input end_variable, input end_command,
                   input string_done, input word_count, output ready);
endinterface

// ===== rtl/command_line_tokenizer.sv =====
// command line tokenizer top level: classifier, state table, counter, output skid
// depends on clt_pkg and the channel interfaces in clt_if.sv
`timescale 1ns / 1ps

// Usage
//   req_ch carries one command string byte per word; byte 0 ends the string.
//   rsp_ch returns one word per byte: the byte when it is copied, the start,
//   end-of-word, end-of-variable and end-of-command marks, string done and
//   the running word count (words and names ended plus commands ended).
//   A taken byte's result goes to the output register, or to the skid register
//   if that one is still waiting; rsp_ch shows the output register. Throughput
//   is one byte per cycle while req_ch.ready is high, set by the state and
//   count registers, updated from a table lookup on state and byte class for
//   each byte taken. An output register and a one-word skid register sit behind
//   that logic, so a byte is still taken while a result waits; req_ch.ready
//   drops only when both hold a word: a byte came while the receiver stalled.
//   Byte 0 returns the parser to the blank state and clears the count.
//   Reset (synchronous) puts the parser in the blank state, clears the
//   count and empties both output registers; nothing else is cleared.

module command_line_tokenizer
   import clt_pkg::*;
   (
   input logic        clock,
   input logic        reset,
   clt_req_if.sink    req_ch,
   clt_rsp_if.source  rsp_ch
   );

   localparam logic [COUNT_WIDTH:0] COUNT_TOP = {1'b0, {COUNT_WIDTH{1'b1}}};

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   rsp_type                out_ff, out_in, skid_ff, skid_in;
   logic                   out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;

   class_type              cls;
   logic [4:0]             flags;
   logic [1:0]             bump;
   logic [COUNT_WIDTH:0]   count_sum;
   logic [COUNT_WIDTH-1:0] count_new;
   logic                   accept;
   logic                   out_take;
   rsp_type                res;

   assign accept   = req_ch.valid & req_ch.ready;
   assign out_take = out_vld_ff & rsp_ch.ready;
   assign req_ch.ready = ~skid_vld_ff;

   always_comb begin
      cls   = classify(req_ch.char_in);
      flags = flags_of(state_ff, cls);
      // a name end and a command end may both land on one byte
      bump  = 2'({1'b0, |(flags & (F_EWORD | F_EVAR))}) + 2'({1'b0, |(flags & F_ECMD)});
      count_sum = {1'b0, count_ff} + (COUNT_WIDTH+1)'(bump);
      count_new = (count_sum >= COUNT_TOP) ? COUNT_TOP[COUNT_WIDTH-1:0]
                                           : count_sum[COUNT_WIDTH-1:0];

      res.copy_flag    = |(flags & F_COPY);
      res.out_char     = res.copy_flag ? req_ch.char_in : '0;
      res.start_word   = |(flags & F_START);
      res.end_word     = |(flags & F_EWORD);
      res.end_variable = |(flags & F_EVAR);
      res.end_command  = |(flags & F_ECMD);
      res.string_done  = (cls == CLS_END);
      res.word_count   = WCNT_WIDTH'(count_new);

      state_in = state_ff;
      count_in = count_ff;
      if (accept) begin
         if (cls == CLS_END) begin
            state_in = ST_BLANK;
            count_in = '0;
         end else begin
            state_in = next_state(state_ff, cls);
            count_in = count_new;
         end
      end
   end

   // output register with one skid word behind it
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (out_take || !out_vld_ff) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else if (accept) begin
            out_in     = res;
            out_vld_in = 1'b1;
         end else begin
            out_vld_in = 1'b0;
         end
      end else if (accept) begin
         skid_in     = res;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_BLANK;
         count_ff    <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.out_char     = out_ff.out_char;
   assign rsp_ch.copy_flag    = out_ff.copy_flag;
   assign rsp_ch.start_word   = out_ff.start_word;
   assign rsp_ch.end_word     = out_ff.end_word;
   assign rsp_ch.end_variable = out_ff.end_variable;
   assign rsp_ch.end_command  = out_ff.end_command;
   assign rsp_ch.string_done  = out_ff.string_done;
   assign rsp_ch.word_count   = out_ff.word_count;

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for command_line_tokenizer: directed and random byte streams
// depends on clt_pkg, the channel interfaces in clt_if.sv and the tokenizer top level
`timescale 1ns / 1ps

module tb_top;
   import clt_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int LONG_PAIRS   = 100;
   localparam int SETTLE       = 8;

   typedef enum logic [3:0] {
      PS_END   = 4'd0,
      PS_BLANK = 4'd1,
      PS_WORD  = 4'd2,
      PS_SQ    = 4'd3,
      PS_DQ    = 4'd4,
      PS_BSL   = 4'd5,
      PS_SEMI  = 4'd6,
      PS_VAR   = 4'd7,
      PS_EVAR  = 4'd8,
      PS_DQBSL = 4'd9
   } parse_state_type;

   logic clock;
   logic reset;

   clt_req_if req_ch ();
   clt_rsp_if rsp_ch ();

   command_line_tokenizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   parse_state_type        tok_state;
   logic [COUNT_WIDTH-1:0] tok_count;
   rsp_type                char_marks_q[$];
   int                     errors;
   int                     chars_sent;
   int                     stall_cycles;
   bit                     quiet_run;

   always #1 clock = ~clock;

   function automatic class_type char_class(input logic [CHAR_WIDTH-1:0] ch);
      class_type cls;
      cls = CLS_OTHER;
      if (ch == CH_NUL) cls = CLS_END;
      else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF) cls = CLS_BLANK;
      else if (ch == CH_SQ) cls = CLS_SQ;
      else if (ch == CH_DQ) cls = CLS_DQ;
      else if (ch == CH_BSL) cls = CLS_BSL;
      else if (ch == CH_SEMI) cls = CLS_SEMI;
      else if (ch == CH_DOLL) cls = CLS_DOLL;
      return cls;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // rows are indexed by class: end, blank, other, sq, dq, backslash, semicolon, dollar
   function automatic rsp_type mark_char(input logic [CHAR_WIDTH-1:0] ch);
      class_type       cls;
      logic [0:7][4:0] frow;
      logic [0:7][3:0] nrow;
      logic [4:0]      fl;
      rsp_type         r;
      cls = char_class(ch);
      case (tok_state)
         PS_END: begin
            frow = {F_ECMD, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            nrow = {PS_END, PS_END, PS_END, PS_END, PS_END, PS_END, PS_END, PS_END};
         end
         PS_WORD: begin
            frow = {F_ECMD | F_EWORD, F_EWORD, F_COPY, 5'h00, 5'h00, 5'h00,
                    F_ECMD | F_EWORD, 5'h00};
            nrow = {PS_END, PS_BLANK, PS_WORD, PS_SQ, PS_DQ, PS_BSL, PS_SEMI, PS_WORD};
         end
         PS_SQ: begin
            frow = {F_ECMD | F_EWORD, F_COPY, F_COPY, 5'h00, F_COPY, F_COPY, F_COPY, F_COPY};
            nrow = {PS_END, PS_SQ, PS_SQ, PS_WORD, PS_SQ, PS_SQ, PS_SQ, PS_SQ};
         end
         PS_DQ: begin
            frow = {F_ECMD | F_EWORD, F_COPY, F_COPY, F_COPY, 5'h00, F_COPY, F_COPY, F_COPY};
            nrow = {PS_END, PS_DQ, PS_DQ, PS_DQ, PS_WORD, PS_DQBSL, PS_DQ, PS_DQ};
         end
         PS_BSL: begin
            frow = {F_ECMD | F_EWORD, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY};
            nrow = {PS_END, PS_WORD, PS_WORD, PS_WORD, PS_WORD, PS_WORD, PS_WORD, PS_WORD};
         end
         PS_SEMI: begin
            frow = {F_ECMD, 5'h00, F_START | F_COPY, F_START, F_START, F_START, 5'h00,
                    F_START};
            nrow = {PS_END, PS_SEMI, PS_WORD, PS_SQ, PS_DQ, PS_BSL, PS_SEMI, PS_VAR};
         end
         PS_VAR: begin
            frow = {F_ECMD | F_EVAR, F_EVAR, F_COPY, 5'h00, 5'h00, 5'h00,
                    F_ECMD | F_EVAR, 5'h00};
            nrow = {PS_END, PS_BLANK, PS_VAR, PS_VAR, PS_VAR, PS_VAR, PS_SEMI, PS_VAR};
         end
         PS_EVAR: begin
            frow = {F_ECMD | F_EVAR, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY};
            nrow = {PS_END, PS_VAR, PS_VAR, PS_VAR, PS_VAR, PS_VAR, PS_VAR, PS_VAR};
         end
         PS_DQBSL: begin
            frow = {F_ECMD | F_EWORD, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY, F_COPY};
            nrow = {PS_END, PS_DQ, PS_DQ, PS_DQ, PS_DQ, PS_DQ, PS_DQ, PS_DQ};
         end
         default: begin
            // blank state, and any code that should never appear
            frow = {F_ECMD, 5'h00, F_START | F_COPY, F_START, F_START, F_START, F_ECMD,
                    F_START};
            nrow = {PS_END, PS_BLANK, PS_WORD, PS_SQ, PS_DQ, PS_BSL, PS_SEMI, PS_VAR};
         end
      endcase
      fl = frow[cls];
      if (|(fl & (F_EWORD | F_EVAR))) tok_count = count_up(tok_count);
      if (|(fl & F_ECMD)) tok_count = count_up(tok_count);
      r.copy_flag    = |(fl & F_COPY);
      r.out_char     = r.copy_flag ? ch : '0;
      r.start_word   = |(fl & F_START);
      r.end_word     = |(fl & F_EWORD);
      r.end_variable = |(fl & F_EVAR);
      r.end_command  = |(fl & F_ECMD);
      r.string_done  = (cls == CLS_END);
      r.word_count   = WCNT_WIDTH'(tok_count);
      if (r.string_done) begin
         tok_state = PS_BLANK;
         tok_count = '0;
      end else begin
         tok_state = parse_state_type'(nrow[cls]);
      end
      return r;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] random_char();
      int                    pick;
      logic [CHAR_WIDTH-1:0] ch;
      pick = $urandom_range(99);
      if (pick < 2) ch = CH_NUL;
      else if (pick < 32) ch = 8'h61 + 8'($urandom_range(25));
      else if (pick < 37) ch = CH_SPACE;
      else if (pick < 42) ch = CH_TAB;
      else if (pick < 47) ch = CH_LF;
      else if (pick < 55) ch = CH_SQ;
      else if (pick < 63) ch = CH_DQ;
      else if (pick < 71) ch = CH_BSL;
      else if (pick < 79) ch = CH_SEMI;
      else if (pick < 87) ch = CH_DOLL;
      else ch = 8'($urandom_range(255));
      return ch;
   endfunction

   task automatic push_char(input logic [CHAR_WIDTH-1:0] ch);
      while (!quiet_run && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= ch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      char_marks_q.push_back(mark_char(ch));
      chars_sent++;
   endtask

   // sends the bytes of s and then the terminating byte 0
   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
      push_char(CH_NUL);
   endtask

   task automatic drain_marks();
      req_ch.valid <= 1'b0;
      while (char_marks_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic test_char_classes();
      // extreme bytes, all classes, escapes inside double quotes, variables and semicolons
      push_string("\377 \t\001\n'\200'\"\\\"\" $x;;\\\177 $y\t");
   endtask

   task automatic test_string_ends();
      push_string("");
      push_string("a");
      push_string("'");
      push_string("\"\\");
      push_string("\\");
      push_string("$");
      push_string(";");
      push_string("$a\\");
   endtask

   task automatic test_random_strings();
      int first;
      int n;
      int len;
      first = chars_sent;
      n     = 0;
      while (chars_sent - first < RANDOM_ITEMS) begin
         quiet_run <= (n >= 30 && n < 45);
         len = $urandom_range(30, 1);
         repeat (len) push_char(random_char());
         push_char(CH_NUL);
         // hold the sender off until every word has come back
         if (n % 25 == 12) drain_marks();
         n++;
      end
      quiet_run <= 1'b0;
   endtask

   task automatic test_long_count();
      // each "a;" pair ends a word and a command, so the count climbs by two
      for (int i = 0; i < LONG_PAIRS; i++) begin
         push_char(8'h61);
         push_char(CH_SEMI);
      end
      push_string("b c;");
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= quiet_run || ($urandom_range(99) >= 10);
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.out_char, rsp_ch.copy_flag, rsp_ch.start_word, rsp_ch.end_word,
                rsp_ch.end_variable, rsp_ch.end_command, rsp_ch.string_done,
                rsp_ch.word_count};
         if (char_marks_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: char %h count %0d", got.out_char, got.word_count);
         end else begin
            want = char_marks_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch (exp/act): char %h/%h copy %b/%b start %b/%b ",
                            "eword %b/%b evar %b/%b ecmd %b/%b done %b/%b count %0d/%0d"},
                           want.out_char, got.out_char, want.copy_flag, got.copy_flag,
                           want.start_word, got.start_word, want.end_word, got.end_word,
                           want.end_variable, got.end_variable, want.end_command,
                           got.end_command, want.string_done, got.string_done,
                           want.word_count, got.word_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.char_in = '0;
      rsp_ch.ready   = 1'b0;
      errors         = 0;
      chars_sent     = 0;
      stall_cycles   = 0;
      quiet_run      = 1'b0;
      tok_state      = PS_BLANK;
      tok_count      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_char_classes();
      test_string_ends();
      test_random_strings();
      test_long_count();

      drain_marks();
      if (errors == 0 && char_marks_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
